/* sv/psis_pkg.sv */
`default_nettype none

package psis_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = IDX_W + 1;
	localparam int SUM_W    = CNT_W + 1;

	typedef enum logic [2:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_CLEAR,
		OP_NTH_PRESENT,
		OP_NTH_LOW,
		OP_NTH_HIGH,
		OP_NTH_MISS_LOW,
		OP_NTH_MISS_HIGH
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_SWAP_A,
		ST_SWAP_B,
		ST_QUERY,
		ST_CLEAR,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic wipe;
		logic sweep;
		logic swap_a;
		logic swap_b;
		logic query_cap;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;
		logic act;
		logic sweep_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

/* sv/psis_ram.sv */
`default_nettype none

module psis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* sv/psis_ctrl.sv */
`default_nettype none

module psis_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  psis_pkg::status_t status,
	output psis_pkg::cmd_t    cmd
);

	import psis_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (status.op)
					OP_INSERT, OP_REMOVE: begin
						state_d = status.act ? ST_SWAP_A : ST_FINISH;
					end
					OP_CLEAR: begin
						cmd.wipe = 1'b1;
						state_d  = ST_CLEAR;
					end
					OP_NTH_PRESENT, OP_NTH_LOW, OP_NTH_HIGH,
					OP_NTH_MISS_LOW, OP_NTH_MISS_HIGH: begin
						state_d = ST_QUERY;
					end
				endcase
			end
			ST_SWAP_A: begin
				cmd.swap_a = 1'b1;
				state_d    = ST_SWAP_B;
			end
			ST_SWAP_B: begin
				cmd.swap_b = 1'b1;
				state_d    = ST_FINISH;
			end
			ST_QUERY: begin
				cmd.query_cap = 1'b1;
				state_d       = ST_FINISH;
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/psis_datapath.sv */
`default_nettype none

module psis_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  psis_pkg::cmd_t             cmd,
	output psis_pkg::status_t          status,
	input  logic [2:0]                 operation,
	input  logic [psis_pkg::IDX_W-1:0] element,
	input  logic [psis_pkg::IDX_W-1:0] rank,
	input  logic                       cfg_wr_en,
	input  logic [psis_pkg::CNT_W-1:0] pivot_index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [psis_pkg::CNT_W-1:0] found_index,
	output logic                       is_member,
	output logic [psis_pkg::CNT_W-1:0] member_count,
	output logic [psis_pkg::CNT_W-1:0] high_count
);

	import psis_pkg::*;

	// item registers
	op_t              op_q;
	logic [IDX_W-1:0] elem_q;
	logic [IDX_W-1:0] rank_q;

	// set state
	logic [CNT_W-1:0]    pivot_q;
	logic [CAPACITY-1:0] presence_q;
	logic [CNT_W-1:0]    total_q;
	logic [CNT_W-1:0]    high_q;
	logic [IDX_W-1:0]    sweep_q;

	// swap scratch and query answer
	logic [IDX_W-1:0] other_q;
	logic [IDX_W-1:0] posn_q;
	logic [CNT_W-1:0] found_q;

	// output register
	logic             out_valid_q;
	logic [CNT_W-1:0] found_index_q;
	logic             is_member_q;
	logic [CNT_W-1:0] member_count_q;
	logic [CNT_W-1:0] high_count_q;

	logic [CNT_W-1:0] pv;
	logic [CNT_W-1:0] low;
	logic             present;
	logic             high_side;
	logic             sweep_last;
	logic [SUM_W-1:0] pv_s, high_s, low_s, n_s, cap_s;
	logic [SUM_W-1:0] ins_slot, rem_slot, upd_slot;
	logic             ins_ok, rem_ok, act, is_update;
	logic [SUM_W-1:0] q_addr, q_m, q_miss, q_rest;
	logic             q_hit;

	logic             ord_we, pos_we;
	logic [IDX_W-1:0] ord_waddr, ord_wdata, pos_waddr, pos_wdata;
	logic [IDX_W-1:0] ord_raddr, ord_rdata, pos_rdata;

	assign pv        = (pivot_q >= CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : pivot_q;
	assign low       = total_q - high_q;
	assign present   = presence_q[elem_q];
	assign high_side = {1'b0, elem_q} >= pv;
	assign sweep_last = (sweep_q == IDX_W'(CAPACITY - 1));

	assign pv_s   = SUM_W'(pv);
	assign high_s = SUM_W'(high_q);
	assign low_s  = SUM_W'(low);
	assign n_s    = SUM_W'(rank_q);
	assign cap_s  = SUM_W'(CAPACITY);

	// boundary slot of the element's region
	assign ins_slot = high_side ? pv_s + high_s : low_s;
	assign rem_slot = high_side ? pv_s + high_s - SUM_W'(1) : low_s - SUM_W'(1);
	assign ins_ok   = !present && (ins_slot < cap_s);
	assign rem_ok   = present && (high_side ? (high_q != '0) : (low != '0)) &&
	                  (rem_slot < cap_s);
	assign is_update = (op_q == OP_INSERT) || (op_q == OP_REMOVE);
	assign upd_slot  = (op_q == OP_INSERT) ? ins_slot : rem_slot;
	assign act       = (op_q == OP_INSERT) ? ins_ok :
	                   (op_q == OP_REMOVE) ? rem_ok : 1'b0;

	always_comb begin
		q_hit  = 1'b0;
		q_addr = '0;
		q_m    = n_s - low_s;
		q_miss = '0;
		q_rest = cap_s - pv_s;
		unique case (op_q)
			OP_NTH_PRESENT: begin
				if (n_s < low_s) begin
					q_hit  = 1'b1;
					q_addr = n_s;
				end else if ((q_m < high_s) && (pv_s + q_m < cap_s)) begin
					q_hit  = 1'b1;
					q_addr = pv_s + q_m;
				end
			end
			OP_NTH_LOW: begin
				if (n_s < low_s) begin
					q_hit  = 1'b1;
					q_addr = n_s;
				end
			end
			OP_NTH_HIGH: begin
				if ((n_s < high_s) && (pv_s + n_s < cap_s)) begin
					q_hit  = 1'b1;
					q_addr = pv_s + n_s;
				end
			end
			OP_NTH_MISS_LOW: begin
				q_miss = (pv_s > low_s) ? pv_s - low_s : '0;
				if (n_s < q_miss) begin
					q_hit  = 1'b1;
					q_addr = low_s + n_s;
				end
			end
			OP_NTH_MISS_HIGH: begin
				q_miss = (q_rest > high_s) ? q_rest - high_s : '0;
				if (n_s < q_miss) begin
					q_hit  = 1'b1;
					q_addr = pv_s + high_s + n_s;
				end
			end
			OP_INSERT, OP_REMOVE, OP_CLEAR: begin
				q_hit = 1'b0;
			end
		endcase
	end

	assign ord_raddr = is_update ? upd_slot[IDX_W-1:0] : q_addr[IDX_W-1:0];

	// table write ports: identity sweep, then the two halves of a swap
	always_comb begin
		ord_we    = 1'b0;
		pos_we    = 1'b0;
		ord_waddr = sweep_q;
		ord_wdata = sweep_q;
		pos_waddr = sweep_q;
		pos_wdata = sweep_q;
		if (cmd.sweep) begin
			ord_we = 1'b1;
			pos_we = 1'b1;
		end else if (cmd.swap_a) begin
			ord_we    = 1'b1;
			pos_we    = 1'b1;
			ord_waddr = upd_slot[IDX_W-1:0];
			ord_wdata = elem_q;
			pos_waddr = elem_q;
			pos_wdata = upd_slot[IDX_W-1:0];
		end else if (cmd.swap_b) begin
			ord_we    = 1'b1;
			pos_we    = 1'b1;
			ord_waddr = posn_q;
			ord_wdata = other_q;
			pos_waddr = other_q;
			pos_wdata = posn_q;
		end
	end

	psis_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_order (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.raddr (ord_raddr),
		.rdata (ord_rdata)
	);

	psis_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_position (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.raddr (elem_q),
		.rdata (pos_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_q     <= '0;
			presence_q  <= '0;
			total_q     <= '0;
			high_q      <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				pivot_q <= pivot_index;
			end
			if (cmd.sweep) begin
				sweep_q <= sweep_last ? '0 : sweep_q + IDX_W'(1);
			end
			if (cmd.wipe) begin
				presence_q <= '0;
				total_q    <= '0;
				high_q     <= '0;
			end else if (cmd.swap_b) begin
				presence_q[elem_q] <= (op_q == OP_INSERT);
				if (op_q == OP_INSERT) begin
					total_q <= total_q + CNT_W'(1);
					high_q  <= high_q + CNT_W'(high_side);
				end else begin
					total_q <= total_q - CNT_W'(1);
					high_q  <= high_q - CNT_W'(high_side);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(operation);
			elem_q  <= element;
			rank_q  <= rank;
			found_q <= CNT_W'(CAPACITY);
		end
		if (cmd.swap_a) begin
			other_q <= ord_rdata;
			posn_q  <= pos_rdata;
		end
		if (cmd.query_cap && q_hit) begin
			found_q <= {1'b0, ord_rdata};
		end
		if (cmd.emit) begin
			found_index_q  <= found_q;
			is_member_q    <= presence_q[elem_q];
			member_count_q <= total_q;
			high_count_q   <= high_q;
		end
	end

	assign status.op         = op_q;
	assign status.act        = act;
	assign status.sweep_last = sweep_last;
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign found_index  = found_index_q;
	assign is_member    = is_member_q;
	assign member_count = member_count_q;
	assign high_count   = high_count_q;

endmodule

`default_nettype wire

/* sv/partitioned_sparse_index_set_unit.sv */
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    operation, element, rank
// out       output     out_valid/out_ready  found_index, is_member, member_count, high_count
// cfg       input      cfg_wr_en            pivot_index
//
// A new input is taken only once the last item is done: a query passes decode and query,
// an insert or remove that moves an entry passes decode, SWAP_A and SWAP_B, one that
// changes nothing skips the swap, and a clear sweeps every entry. The order and
// position RAMs have one write port each and a registered read, so a swap reads both
// and writes them in SWAP_A and SWAP_B. Reset starts an identity fill of both RAMs;
// in_ready stays low until it ends. One output register holds a finished result; the
// next item is taken while it waits and holds in its last step until the register frees.
`default_nettype none

module partitioned_sparse_index_set_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 operation,
	input  logic [psis_pkg::IDX_W-1:0] element,
	input  logic [psis_pkg::IDX_W-1:0] rank,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [psis_pkg::CNT_W-1:0] found_index,
	output logic                       is_member,
	output logic [psis_pkg::CNT_W-1:0] member_count,
	output logic [psis_pkg::CNT_W-1:0] high_count,
	input  logic                       cfg_wr_en,
	input  logic [psis_pkg::CNT_W-1:0] pivot_index
);

	import psis_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer: accept one item, step it through decode, swap, query or clear sweep,
	// and hand the result to the output register.
	psis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: presence bits, counts, pivot, the two permutation RAMs
	// (order and its inverse) and the output register.
	psis_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.operation    (operation),
		.element      (element),
		.rank         (rank),
		.cfg_wr_en    (cfg_wr_en),
		.pivot_index  (pivot_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found_index  (found_index),
		.is_member    (is_member),
		.member_count (member_count),
		.high_count   (high_count)
	);

endmodule

`default_nettype wire

/* sv/psis_checker.sv */
`default_nettype none

module psis_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [psis_pkg::CNT_W-1:0] found_index,
	input logic                       is_member,
	input logic [psis_pkg::CNT_W-1:0] member_count,
	input logic [psis_pkg::CNT_W-1:0] high_count
);

	import psis_pkg::*;

	// one item in flight: ready drops right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an input transfer");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (high_count <= member_count) &&
		              (member_count <= CNT_W'(CAPACITY)))
		else $error("high_count or member_count out of range");

	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> found_index <= CNT_W'(CAPACITY))
		else $error("found_index beyond capacity");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({found_index, is_member, member_count, high_count}))
		else $error("stalled result changed");

endmodule

bind partitioned_sparse_index_set_unit psis_checker u_psis_checker (.*);

`default_nettype wire
